FILE: sv/fpba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// shared constants and codes for the fit policy block allocator
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int FUNC_W   = 1;
    localparam int SLOT_W   = 4;
    localparam int AMOUNT_W = 16;
    localparam int CHOSEN_W = 4;
    localparam int LEFT_W   = 16;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam int POLICY_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    typedef struct packed {
        logic fits;
        logic take;
    } fpba_cmp_t;

endpackage

FILE: sv/fpba_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_compare
// compare unit: decides whether a scanned block replaces the current pick
// ----------------------------------------------------------------------------
module fpba_compare
    import fpba_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                 cand_valid,
    input  logic [SIZE_BITS-1:0] cand_size,
    input  logic [SIZE_BITS-1:0] amount,
    input  logic [SIZE_BITS-1:0] best_size,
    input  logic                 found,
    input  logic [POLICY_W-1:0]  policy,
    output fpba_cmp_t            result
);

    logic fits;
    logic better;

    always_comb
    begin
        fits = cand_valid && (cand_size >= amount);
        case (policy)
            POLICY_BEST:  better = cand_size < best_size;
            POLICY_WORST: better = cand_size > best_size;
            default:      better = 1'b0;
        endcase
        result.fits = fits;
        result.take = fits && (!found || better);
    end

endmodule

FILE: sv/fit_policy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// block table with first, best or worst fit search and in-place reduction
// ----------------------------------------------------------------------------
// load request: no result
// allocation request: scans up to limit entries, limit being
//   min(block_count, NUM_BLOCKS); one table read and one compare per cycle
// one request in flight: next request taken once the result is registered, which
//   waits while an earlier result is still held; first fit ends the scan at the first fit
// reset: table reads as zero (per-entry valid bits), fit_policy 0, block_count 16
// ----------------------------------------------------------------------------
module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // func, slot[3:0], amount[15:0], pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // granted, chosen_block[3:0], left_over[15:0], pad
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [POLICY_W-1:0]   policy_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [NUM_BLOCKS-1:0] valid_reg;

    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      lim_reg, lim_next;
    logic                  pend_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic                  pend_vld_reg;
    logic [SIZE_BITS-1:0]  rd_data_reg;
    logic [SIZE_BITS-1:0]  amt_reg, amt_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [SIZE_BITS-1:0]  best_reg, best_next;

    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];

    logic [FUNC_W-1:0]     in_func;
    logic [SLOT_W-1:0]     in_slot;
    logic [AMOUNT_W-1:0]   in_amount;
    logic                  accept;
    logic                  slot_ok;
    logic                  first_mode;
    logic                  issue;
    logic [SIZE_BITS-1:0]  cand_size;
    logic [SIZE_BITS-1:0]  remainder;
    logic                  finish;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    logic [SIZE_BITS-1:0]  mem_wd;
    fpba_cmp_t             cmp;

    assign in_func   = s_tdata[0];
    assign in_slot   = s_tdata[4:1];
    assign in_amount = s_tdata[20:5];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign slot_ok  = (32'(in_slot) < NUM_BLOCKS);

    assign first_mode = !((policy_reg == POLICY_BEST) || (policy_reg == POLICY_WORST));
    assign issue      = (state_reg == ST_SCAN) && (idx_reg != lim_reg)
                        && !(found_reg && first_mode);
    assign cand_size  = pend_vld_reg ? rd_data_reg : '0;
    assign remainder  = best_reg - amt_reg;
    assign finish     = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    fpba_compare #(
        .SIZE_BITS (SIZE_BITS)
    ) u_compare (
        .cand_valid (pend_reg),
        .cand_size  (cand_size),
        .amount     (amt_reg),
        .best_size  (best_reg),
        .found      (found_reg),
        .policy     (policy_reg),
        .result     (cmp)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        amt_next   = amt_reg;
        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        mem_we     = 1'b0;
        mem_wa     = IDX_W'(in_slot);
        mem_wd     = SIZE_BITS'(in_amount);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_func == FUNC_REQUEST)
                    begin
                        state_next = ST_SCAN;
                        idx_next   = '0;
                        lim_next   = (32'(count_reg) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                                   : CNT_W'(count_reg);
                        amt_next   = SIZE_BITS'(in_amount);
                        found_next = 1'b0;
                        pick_next  = '0;
                        best_next  = '0;
                    end
                    else
                    begin
                        mem_we = slot_ok;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (cmp.take)
                begin
                    found_next = 1'b1;
                    pick_next  = pend_idx_reg;
                    best_next  = cand_size;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                    mem_we     = found_reg;
                    mem_wa     = pick_reg;
                    mem_wd     = remainder;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            policy_reg    <= POLICY_FIRST;
            count_reg     <= COUNT_RESET;
            valid_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            pend_reg  <= issue;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FIT_POLICY:  policy_reg <= cfg_data[POLICY_W-1:0];
                    REG_BLOCK_COUNT: count_reg  <= cfg_data[COUNT_W-1:0];
                    default:         ;
                endcase
            end
            if (mem_we)
            begin
                valid_reg[mem_wa] <= 1'b1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        lim_reg  <= lim_next;
        amt_reg  <= amt_next;
        pick_reg <= pick_next;
        best_reg <= best_next;
        if (issue)
        begin
            pend_idx_reg <= idx_reg[IDX_W-1:0];
            pend_vld_reg <= valid_reg[idx_reg[IDX_W-1:0]];
        end
        if (finish)
        begin
            if (found_reg)
            begin
                out_data_reg <= {3'b000, LEFT_W'(remainder), CHOSEN_W'(pick_reg), 1'b1};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (issue)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
